// File: rtl/rbq_pkg.sv
package rbq_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam int WORD_W = 32;
  localparam int MODE_W = 3;
  localparam int OFF_W  = 4;
  localparam int STAT_W = 2;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DIST_W = (CNT_W > OFF_W) ? CNT_W : OFF_W;
  localparam int SUM_W  = DIST_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH      = 3'd0,
    MODE_POP       = 3'd1,
    MODE_READ_AT   = 3'd2,
    MODE_READ_HEAD = 3'd3,
    MODE_READ_TAIL = 3'd4,
    MODE_CLEAR     = 3'd5
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_EMPTY_RANGE = 2'd2
  } status_t;

endpackage

// File: rtl/ring_buffer_queue_unit.sv
// The result strobe out_valid is high in the cycle right after the request is taken.
// Throughput: one request per cycle while not busy; each request does at most one access
// to the single-port ring memory (registered read), so nothing limits the rate below one
// per cycle. Reset: synchronous, active low; clears head, tail and count; busy stays high
// in reset and in the cycle after it. Ring memory is not cleared. The receiver cannot stall.
module ring_buffer_queue_unit import rbq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [WORD_W-1:0] in_push_word,
  input  logic [OFF_W-1:0]         in_offset,
  output logic                     out_valid,
  output logic signed [WORD_W-1:0] out_read_word,
  output logic [CNT_W-1:0]         out_count,
  output logic [STAT_W-1:0]        out_status
);

  logic signed [WORD_W-1:0] ring_mem [QUEUE_DEPTH];

  logic                     busy_r;
  logic                     out_valid_r;
  logic [PTR_W-1:0]         head_r, head_nxt;
  logic [PTR_W-1:0]         tail_r, tail_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  status_t                  status_r, status_nxt;
  logic                     rd_hit_r, rd_hit_nxt;
  logic signed [WORD_W-1:0] rd_data_r;

  logic                     accept;
  mode_t                    mode;
  logic [DIST_W-1:0]        span;
  logic [SUM_W-1:0]         sum;
  logic [PTR_W-1:0]         rd_addr;
  logic                     wr_en;

  assign accept = start && !busy_r;
  assign mode   = mode_t'(in_mode);

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PTR_W'(1);
    end
    return q;
  endfunction

  // head + span stays below twice the depth when in range: one subtract wraps it
  assign sum     = SUM_W'(head_r) + SUM_W'(span);
  assign rd_addr = (sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(sum - SUM_W'(QUEUE_DEPTH))
                                                 : PTR_W'(sum);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_hit_nxt = 1'b0;
    wr_en      = 1'b0;
    span       = '0;
    case (mode)
      MODE_PUSH: begin
        if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          tail_nxt  = ring_advance(tail_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_POP: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY_RANGE;
        end else begin
          head_nxt  = ring_advance(head_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      MODE_READ_AT: begin
        span = DIST_W'(in_offset);
        if (DIST_W'(in_offset) >= DIST_W'(count_r)) begin
          status_nxt = ST_EMPTY_RANGE;
        end else begin
          rd_hit_nxt = 1'b1;
        end
      end
      MODE_READ_HEAD: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY_RANGE;
        end else begin
          rd_hit_nxt = 1'b1;
        end
      end
      MODE_READ_TAIL: begin
        span = DIST_W'(count_r - CNT_W'(1));
        if (count_r == '0) begin
          status_nxt = ST_EMPTY_RANGE;
        end else begin
          rd_hit_nxt = 1'b1;
        end
      end
      MODE_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      ring_mem[tail_r] <= in_push_word;
    end
  end

  // a push lands before the next request reads, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (accept && rd_hit_nxt) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      status_r    <= ST_OK;
      rd_hit_r    <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        count_r  <= count_nxt;
        status_r <= status_nxt;
        rd_hit_r <= rd_hit_nxt;
      end
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_count     = count_r;
  assign out_status    = status_r;
  assign out_read_word = rd_hit_r ? rd_data_r : '0;

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("result strobe missing after request");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result strobe without request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_count == CNT_W'(QUEUE_DEPTH))
    else $error("full status with queue not full");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_read_word == '0)
    else $error("nonzero word on refused request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(QUEUE_DEPTH))
    else $error("count beyond depth");

endmodule

// File: verif/ring_buffer_queue_unit_checker.sv
module ring_buffer_queue_unit_checker
  import rbq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [WORD_W-1:0] in_push_word,
  input  logic [OFF_W-1:0]         in_offset,
  input  logic                     out_valid,
  input  logic signed [WORD_W-1:0] out_read_word,
  input  logic [CNT_W-1:0]         out_count,
  input  logic [STAT_W-1:0]        out_status,
  output int                       fail_count,
  output int                       pending,
  output int                       checked,
  output int                       full_seen,
  output int                       range_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [WORD_W-1:0] word;
    logic [CNT_W-1:0]         count;
    status_t                  status;
  } queue_reply_t;

  logic signed [WORD_W-1:0] ring_model [QUEUE_DEPTH];
  logic [PTR_W-1:0]         head_idx;
  logic [PTR_W-1:0]         tail_idx;
  logic [CNT_W-1:0]         fill;
  queue_reply_t             reply_queue [$];
  int                       fails;
  int                       n_checked;
  int                       n_full;
  int                       n_range;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_at(input int span);
    return PTR_W'((int'(head_idx) + span) % QUEUE_DEPTH);
  endfunction

  // Apply one request to the queue image and return the reply it should give.
  function automatic queue_reply_t apply_request(input logic [MODE_W-1:0] mode,
                                                 input logic signed [WORD_W-1:0] word,
                                                 input logic [OFF_W-1:0] off);
    queue_reply_t r;
    r.word = '0;
    r.status = ST_OK;
    case (mode)
      MODE_PUSH: begin
        if (int'(fill) >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_model[tail_idx] = word;
          tail_idx = ring_next(tail_idx);
          fill = fill + 1'b1;
        end
      end
      MODE_POP: begin
        if (fill == 0) begin
          r.status = ST_EMPTY_RANGE;
        end else begin
          head_idx = ring_next(head_idx);
          fill = fill - 1'b1;
        end
      end
      MODE_READ_AT: begin
        if (int'(off) >= int'(fill)) r.status = ST_EMPTY_RANGE;
        else r.word = ring_model[ring_at(int'(off))];
      end
      MODE_READ_HEAD: begin
        if (fill == 0) r.status = ST_EMPTY_RANGE;
        else r.word = ring_model[ring_at(0)];
      end
      MODE_READ_TAIL: begin
        if (fill == 0) r.status = ST_EMPTY_RANGE;
        else r.word = ring_model[ring_at(int'(fill) - 1)];
      end
      MODE_CLEAR: begin
        head_idx = '0;
        tail_idx = '0;
        fill = '0;
      end
      default: ;
    endcase
    r.count = fill;
    return r;
  endfunction

  initial begin
    fails = 0;
    n_checked = 0;
    n_full = 0;
    n_range = 0;
    head_idx = '0;
    tail_idx = '0;
    fill = '0;
  end

  always @(posedge clk) begin
    queue_reply_t want;
    if (!rst_n) begin
      head_idx = '0;
      tail_idx = '0;
      fill = '0;
      reply_queue.delete();
    end else begin
      // Results trail their request, so check before taking the new one.
      if (out_valid === 1'b1) begin
        if (reply_queue.size() == 0) begin
          if (fails < 10)
            $display("%0t: result with no request pending: word %0d count %0d status %0d",
                     $realtime, out_read_word, out_count, out_status);
          fails++;
        end else begin
          want = reply_queue.pop_front();
          n_checked++;
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_EMPTY_RANGE) n_range++;
          if (out_read_word !== want.word || out_count !== want.count ||
              out_status !== want.status) begin
            if (fails < 10)
              $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d (word/count/status)",
                       $realtime, want.word, want.count, want.status,
                       out_read_word, out_count, out_status);
            fails++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        reply_queue.push_back(apply_request(in_mode, in_push_word, in_offset));
    end
    fail_count <= fails;
    pending <= reply_queue.size();
    checked <= n_checked;
    full_seen <= n_full;
    range_seen <= n_range;
  end

endmodule

// File: verif/ring_buffer_queue_unit_test.sv
module ring_buffer_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rbq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam int RANDOM_REQUESTS = 1350;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [MODE_W-1:0]        in_mode = MODE_PUSH;
  logic signed [WORD_W-1:0] in_push_word = '0;
  logic [OFF_W-1:0]         in_offset = '0;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_read_word;
  logic [CNT_W-1:0]         out_count;
  logic [STAT_W-1:0]        out_status;

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int range_seen;
  int sent = 0;

  ring_buffer_queue_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_push_word (in_push_word),
    .in_offset    (in_offset),
    .out_valid    (out_valid),
    .out_read_word(out_read_word),
    .out_count    (out_count),
    .out_status   (out_status)
  );

  ring_buffer_queue_unit_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_push_word (in_push_word),
    .in_offset    (in_offset),
    .out_valid    (out_valid),
    .out_read_word(out_read_word),
    .out_count    (out_count),
    .out_status   (out_status),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .full_seen    (full_seen),
    .range_seen   (range_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("ring_buffer_queue_unit: mismatch");
    $finish;
  end

  // Hold the request until the block takes it; keep start high when no gap follows.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic signed [WORD_W-1:0] word,
                              input logic [OFF_W-1:0] off);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_push_word <= word;
    in_offset <= off;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent++;
  endtask

  initial begin
    int useful;
    int phase_left;
    int push_weight;
    int pick;
    logic [MODE_W-1:0] mode;
    logic signed [WORD_W-1:0] word;
    logic [OFF_W-1:0] off;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue and spare modes
    send_request(MODE_POP, $urandom, 4'h0);
    send_request(MODE_READ_HEAD, $urandom, 4'h0);
    send_request(MODE_READ_TAIL, $urandom, 4'h0);
    send_request(MODE_READ_AT, $urandom, 4'h0);
    send_request(MODE_SPARE_A, $urandom, 4'hF);
    send_request(MODE_SPARE_B, $urandom, 4'hA);
    // extreme words, then reads across the live range and past it
    send_request(MODE_PUSH, 32'sh7FFF_FFFF, 4'h0);
    send_request(MODE_PUSH, 32'sh8000_0000, 4'h5);
    send_request(MODE_PUSH, 32'sh0000_0000, 4'hA);
    send_request(MODE_PUSH, -32'sd1, 4'hF);
    send_request(MODE_READ_HEAD, $urandom, 4'h0);
    send_request(MODE_READ_TAIL, $urandom, 4'h0);
    send_request(MODE_READ_AT, $urandom, 4'h1);
    send_request(MODE_READ_AT, $urandom, 4'h3);
    send_request(MODE_READ_AT, $urandom, 4'h4);
    send_request(MODE_READ_AT, $urandom, 4'hF);
    send_request(MODE_POP, $urandom, 4'h0);
    send_request(MODE_READ_HEAD, $urandom, 4'h0);
    send_request(MODE_CLEAR, $urandom, 4'h0);
    send_request(MODE_READ_TAIL, $urandom, 4'h0);
    send_request(MODE_PUSH, 32'sh1234_5678, 4'h0);
    send_request(MODE_READ_TAIL, $urandom, 4'h0);

    useful = 0;
    phase_left = 0;
    push_weight = 50;
    while (useful < RANDOM_REQUESTS) begin
      // each phase leans toward filling, draining or balance
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 80);
        pick = $urandom_range(0, 2);
        push_weight = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
      end
      phase_left--;
      if ($urandom_range(0, 99) < push_weight) begin
        mode = MODE_PUSH;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) mode = MODE_POP;
        else if (pick < 60) mode = MODE_READ_AT;
        else if (pick < 75) mode = MODE_READ_HEAD;
        else if (pick < 90) mode = MODE_READ_TAIL;
        else if (pick < 94) mode = MODE_CLEAR;
        else mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
      end
      case ($urandom_range(0, 15))
        0: word = 32'sh7FFF_FFFF;
        1: word = 32'sh8000_0000;
        2: word = '0;
        3: word = -32'sd1;
        default: word = $urandom;
      endcase
      off = $urandom_range(0, 1) ? OFF_W'($urandom_range(0, 3))
                                 : OFF_W'($urandom_range(0, 15));
      send_request(mode, word, off);
      if (mode != MODE_SPARE_A && mode != MODE_SPARE_B) useful++;
    end
    start <= 1'b0;

    for (int i = 0; i < 1000 && pending != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d requests, %0d results checked", sent, checked);
    $display("saw %0d refused pushes and %0d empty or out-of-range requests",
             full_seen, range_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ring_buffer_queue_unit: match");
    end else begin
      $display("ring_buffer_queue_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rbq_pkg.sv
rtl/ring_buffer_queue_unit.sv
verif/ring_buffer_queue_unit_checker.sv
verif/ring_buffer_queue_unit_test.sv
